[hdl/dst_pkg.sv]
// shared constants, codes and helpers for the dual stack block
package dst_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int OUT_CNT_W   = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 3'd0,
    MODE_PUSH  = 3'd1,
    MODE_POP   = 3'd2,
    MODE_XFER  = 3'd3,
    MODE_REV   = 3'd4,
    MODE_CMP   = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  function automatic logic [OUT_CNT_W-1:0] out_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] wide;
    wide = {{OUT_CNT_W{1'b0}}, c};
    return wide[OUT_CNT_W-1:0];
  endfunction

endpackage

[hdl/dst_cmd_if.sv]
// command channel: operation and key
interface dst_cmd_if
  import dst_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [KEY_W-1:0]  key_in;

  modport source (output valid, output mode, output key_in, input ready);
  modport sink   (input valid, input mode, input key_in, output ready);
endinterface

[hdl/dst_res_if.sv]
// result channel: status, key and both counts
interface dst_res_if
  import dst_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [KEY_W-1:0]  key_out;
  logic                     a_larger;
  logic [OUT_CNT_W-1:0]     count_a_out;
  logic [OUT_CNT_W-1:0]     count_b_out;

  modport source (output valid, output status, output key_out, output a_larger,
                  output count_a_out, output count_b_out, input ready);
  modport sink   (input valid, input status, input key_out, input a_larger,
                  input count_a_out, input count_b_out, output ready);
endinterface

[hdl/dst_ram.sv]
// generic single write port, single read port ram with registered read
module dst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                   wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                   rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/dual_stack_transfer_reverse_top.sv]
// top level of the dual stack block: control sequencer and both stack stores
//
// Two bounded stacks A and B of 32-bit signed keys, each held in its own RAM
// with a registered read; both stacks are empty after reset. Every
// command item returns one result item, held in an output register, so a new
// command is taken while the previous result still waits. Clear, push, compare
// and refused pop or push go straight to the result state; a pop first reads
// its key in S_POP_RD. Transfer streams A onto B through the read port of A.
// Reverse swaps one pair of entries at a time through the single read port of
// A, stepping through S_REV_RDHI, S_REV_WRLO and S_REV_WRHI for each pair.
module dual_stack_transfer_reverse_top
  import dst_pkg::*;
(
  input logic       clk,
  input logic       rst,
  dst_cmd_if.sink   cmd,
  dst_res_if.source res
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_POP_RD   = 7'b0000010,
    S_XFER     = 7'b0000100,
    S_REV_RDHI = 7'b0001000,
    S_REV_WRLO = 7'b0010000,
    S_REV_WRHI = 7'b0100000,
    S_RESULT   = 7'b1000000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count_a;
  logic [CNT_W-1:0]      count_b;
  logic [CNT_W-1:0]      xfer_left;
  logic [ADDR_W-1:0]     b_idx;
  logic [ADDR_W-1:0]     lo;
  logic [ADDR_W-1:0]     hi;
  logic [KEY_W-1:0]      tmp;
  logic [STATUS_W-1:0]   status_r;
  logic [KEY_W-1:0]      kout_r;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [KEY_W-1:0]      out_key;
  logic                  out_larger;
  logic [OUT_CNT_W-1:0]  out_cnt_a;
  logic [OUT_CNT_W-1:0]  out_cnt_b;

  logic                  a_wr_en;
  logic [ADDR_W-1:0]     a_wr_addr;
  logic [KEY_W-1:0]      a_wr_data;
  logic [ADDR_W-1:0]     a_rd_addr;
  logic [KEY_W-1:0]      a_rd_data;
  logic                  b_wr_en;

  logic                  accept;
  logic                  load;
  logic [CNT_W-1:0]      count_a_m1;
  logic [CNT_W-1:0]      xfer_left_m1;
  logic [ADDR_W-1:0]     lo_p1;
  logic                  rev_more;

  assign cmd.ready    = (state == S_IDLE);
  assign accept       = cmd.valid && cmd.ready;
  assign load         = (state == S_RESULT) && (!out_valid || res.ready);
  assign count_a_m1   = count_a - 1'b1;
  assign xfer_left_m1 = xfer_left - 1'b1;
  assign lo_p1        = lo + 1'b1;
  assign rev_more     = ({1'b0, lo} + {{ADDR_W{1'b0}}, 1'b0} + 2'd2) < {1'b0, hi};

  // port muxing for stack a
  always_comb begin
    a_wr_en   = 1'b0;
    a_wr_addr = count_a[ADDR_W-1:0];
    a_wr_data = cmd.key_in;
    a_rd_addr = count_a_m1[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept && cmd.mode == MODE_PUSH && count_a < CNT_W'(STACK_DEPTH)) begin
          a_wr_en = 1'b1;
        end
        if (cmd.mode == MODE_REV) begin
          a_rd_addr = '0;
        end
      end
      S_XFER: begin
        a_rd_addr = xfer_left_m1[ADDR_W-1:0];
      end
      S_REV_RDHI: begin
        a_rd_addr = hi;
      end
      S_REV_WRLO: begin
        a_wr_en   = 1'b1;
        a_wr_addr = lo;
        a_wr_data = a_rd_data;
      end
      S_REV_WRHI: begin
        a_wr_en   = 1'b1;
        a_wr_addr = hi;
        a_wr_data = tmp;
        a_rd_addr = lo_p1;
      end
      default: begin
      end
    endcase
  end

  assign b_wr_en = (state == S_XFER);

  dst_ram #(.WIDTH(KEY_W), .DEPTH(STACK_DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (a_wr_data),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  dst_ram #(.WIDTH(KEY_W), .DEPTH(STACK_DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_idx),
    .wr_data (a_rd_data),
    .rd_addr ('0),
    .rd_data ()
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_a <= '0;
      count_b <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            kout_r <= '0;
            case (cmd.mode)
              MODE_CLEAR: begin
                status_r <= ST_OK;
                count_a  <= '0;
                state    <= S_RESULT;
              end
              MODE_PUSH: begin
                state <= S_RESULT;
                if (count_a < CNT_W'(STACK_DEPTH)) begin
                  status_r <= ST_OK;
                  count_a  <= count_a + 1'b1;
                end else begin
                  status_r <= ST_FULL;
                end
              end
              MODE_POP: begin
                if (count_a == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_RESULT;
                end else begin
                  status_r <= ST_OK;
                  count_a  <= count_a_m1;
                  state    <= S_POP_RD;
                end
              end
              MODE_XFER: begin
                status_r <= ST_OK;
                if (count_a == '0) begin
                  count_b <= '0;
                  state   <= S_RESULT;
                end else begin
                  xfer_left <= count_a_m1;
                  b_idx     <= '0;
                  state     <= S_XFER;
                end
              end
              MODE_REV: begin
                status_r <= ST_OK;
                lo       <= '0;
                hi       <= count_a_m1[ADDR_W-1:0];
                state    <= (count_a > CNT_W'(1)) ? S_REV_RDHI : S_RESULT;
              end
              default: begin
                status_r <= ST_OK;
                state    <= S_RESULT;
              end
            endcase
          end
        end
        S_POP_RD: begin
          kout_r <= a_rd_data;
          state  <= S_RESULT;
        end
        S_XFER: begin
          b_idx <= b_idx + 1'b1;
          if (xfer_left != '0) begin
            xfer_left <= xfer_left_m1;
          end else begin
            kout_r  <= a_rd_data;
            count_b <= count_a;
            count_a <= '0;
            state   <= S_RESULT;
          end
        end
        S_REV_RDHI: begin
          tmp   <= a_rd_data;
          state <= S_REV_WRLO;
        end
        S_REV_WRLO: begin
          state <= S_REV_WRHI;
        end
        S_REV_WRHI: begin
          lo <= lo_p1;
          hi <= hi - 1'b1;
          state <= rev_more ? S_REV_RDHI : S_RESULT;
        end
        S_RESULT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= status_r;
      out_key    <= kout_r;
      out_larger <= (count_a > count_b);
      out_cnt_a  <= out_count(count_a);
      out_cnt_b  <= out_count(count_b);
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.key_out     = out_key;
  assign res.a_larger    = out_larger;
  assign res.count_a_out = out_cnt_a;
  assign res.count_b_out = out_cnt_b;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CNT_W'(STACK_DEPTH)) && (count_b <= CNT_W'(STACK_DEPTH)))
    else $error("stack count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.mode == MODE_PUSH && count_a < CNT_W'(STACK_DEPTH))
    |=> (count_a == $past(count_a) + 1'b1))
    else $error("push did not grow stack a");

  a_xfer_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_XFER && xfer_left == '0)
    |=> (count_a == '0 && count_b == $past(count_a) && state == S_RESULT))
    else $error("transfer end left wrong counts");

endmodule

[tb/sv/dual_stack_transfer_reverse_top_tb.sv]
// self-checking testbench for the dual stack block: directed table, random mix, scoreboard
`timescale 1ns / 1ps

module dual_stack_transfer_reverse_top_tb
  import dst_pkg::*;
;

  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;
  localparam int TOTAL_ITEMS    = 950;
  localparam int IDLE_LIMIT     = 5000;
  localparam int TAIL_CYCLES    = 50;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     key;
    logic                 a_larger;
    logic [OUT_CNT_W-1:0] count_a;
    logic [OUT_CNT_W-1:0] count_b;
  } stack_result_t;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [KEY_W-1:0]  key;
    bit                drain;
    bit                has_fixed;
    stack_result_t     fixed_res;
  } stack_cmd_t;

  logic clk;
  logic rst;

  dst_cmd_if cmd_ch ();
  dst_res_if res_ch ();

  dual_stack_transfer_reverse_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  stack_cmd_t    cmd_plan[$];
  stack_result_t pending_results[$];

  logic [KEY_W-1:0] model_a[STACK_DEPTH];
  logic [KEY_W-1:0] model_b[STACK_DEPTH];
  int model_cnt_a = 0;
  int model_cnt_b = 0;

  int results_seen = 0;
  int cmds_taken   = 0;
  int fail_count   = 0;
  int idle_cycles  = 0;

  function automatic stack_result_t predict_stack_op(logic [MODE_W-1:0] op,
                                                     logic [KEY_W-1:0] key);
    stack_result_t r;
    int n;
    logic [KEY_W-1:0] t;
    r = '0;
    r.status = ST_OK;
    case (op)
      MODE_CLEAR: model_cnt_a = 0;
      MODE_PUSH: begin
        if (model_cnt_a >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_a[model_cnt_a] = key;
          model_cnt_a++;
        end
      end
      MODE_POP: begin
        if (model_cnt_a == 0) begin
          r.status = ST_EMPTY;
        end else begin
          model_cnt_a--;
          r.key = model_a[model_cnt_a];
        end
      end
      MODE_XFER: begin
        n = model_cnt_a;
        for (int i = 0; i < n; i++) model_b[i] = model_a[n - 1 - i];
        if (n > 0) r.key = model_a[0];
        model_cnt_b = n;
        model_cnt_a = 0;
      end
      MODE_REV: begin
        n = model_cnt_a;
        for (int i = 0; i < n / 2; i++) begin
          t = model_a[i];
          model_a[i] = model_a[n - 1 - i];
          model_a[n - 1 - i] = t;
        end
      end
      default: ;
    endcase
    r.a_larger = (model_cnt_a > model_cnt_b);
    r.count_a  = OUT_CNT_W'(model_cnt_a);
    r.count_b  = OUT_CNT_W'(model_cnt_b);
    return r;
  endfunction

  task automatic plan_item(logic [MODE_W-1:0] op, logic [KEY_W-1:0] key, bit drain);
    stack_cmd_t c;
    c.op = op;
    c.key = key;
    c.drain = drain;
    c.has_fixed = 1'b0;
    c.fixed_res = '0;
    cmd_plan.push_back(c);
  endtask

  task automatic plan_fixed(logic [MODE_W-1:0] op, logic [KEY_W-1:0] key,
                            status_t st, logic [KEY_W-1:0] kout, logic al,
                            int ca, int cb);
    stack_cmd_t c;
    c.op = op;
    c.key = key;
    c.drain = 1'b0;
    c.has_fixed = 1'b1;
    c.fixed_res.status = st;
    c.fixed_res.key = kout;
    c.fixed_res.a_larger = al;
    c.fixed_res.count_a = OUT_CNT_W'(ca);
    c.fixed_res.count_b = OUT_CNT_W'(cb);
    cmd_plan.push_back(c);
  endtask

  function automatic logic [MODE_W-1:0] pick_op(int profile);
    int roll;
    roll = $urandom_range(0, 99);
    case (profile)
      0: begin
        if (roll < 70) return MODE_PUSH;
        if (roll < 80) return MODE_POP;
        if (roll < 84) return MODE_REV;
        if (roll < 87) return MODE_XFER;
        if (roll < 92) return MODE_CMP;
        if (roll < 95) return MODE_CLEAR;
        if (roll < 98) return MODE_RSVD6;
        return MODE_RSVD7;
      end
      1: begin
        if (roll < 25) return MODE_PUSH;
        if (roll < 85) return MODE_POP;
        if (roll < 89) return MODE_REV;
        if (roll < 92) return MODE_XFER;
        if (roll < 97) return MODE_CMP;
        return MODE_CLEAR;
      end
      2: return MODE_W'($urandom_range(0, 7));
      default: begin
        if (roll < 45) return MODE_PUSH;
        if (roll < 85) return MODE_POP;
        if (roll < 90) return MODE_REV;
        if (roll < 94) return MODE_XFER;
        return MODE_CMP;
      end
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_plan();
    int profile;
    int seg_len;
    // directed part
    plan_fixed(MODE_POP,   $urandom, ST_EMPTY, 0, 1'b0, 0, 0);
    plan_fixed(MODE_CMP,   0,        ST_OK,    0, 1'b0, 0, 0);
    plan_fixed(MODE_XFER,  0,        ST_OK,    0, 1'b0, 0, 0);
    plan_fixed(MODE_PUSH,  32'h7fff_ffff, ST_OK, 0, 1'b1, 1, 0);
    plan_fixed(MODE_PUSH,  32'h8000_0000, ST_OK, 0, 1'b1, 2, 0);
    plan_fixed(MODE_PUSH,  32'h0000_0000, ST_OK, 0, 1'b1, 3, 0);
    plan_fixed(MODE_PUSH,  32'hffff_ffff, ST_OK, 0, 1'b1, 4, 0);
    plan_item(MODE_REV,    $urandom, 1'b0);
    plan_fixed(MODE_POP,   0, ST_OK, 32'h7fff_ffff, 1'b1, 3, 0);
    plan_fixed(MODE_XFER,  0, ST_OK, 32'hffff_ffff, 1'b0, 0, 3);
    plan_item(MODE_CMP,    $urandom, 1'b0);
    plan_fixed(MODE_POP,   0, ST_EMPTY, 0, 1'b0, 0, 3);
    plan_fixed(MODE_RSVD6, $urandom, ST_OK, 0, 1'b0, 0, 3);
    plan_fixed(MODE_RSVD7, $urandom, ST_OK, 0, 1'b0, 0, 3);
    plan_item(MODE_PUSH,   32'd1, 1'b0);
    plan_item(MODE_PUSH,   32'd2, 1'b0);
    plan_item(MODE_REV,    0, 1'b0);
    plan_item(MODE_PUSH,   32'd3, 1'b0);
    plan_item(MODE_REV,    0, 1'b0);
    plan_item(MODE_POP,    0, 1'b0);
    plan_item(MODE_CMP,    0, 1'b0);
    plan_fixed(MODE_CLEAR, $urandom, ST_OK, 0, 1'b0, 0, 3);
    plan_fixed(MODE_XFER,  0, ST_OK, 0, 1'b0, 0, 0);
    plan_item(MODE_REV,    0, 1'b0);
    plan_item(MODE_PUSH,   32'haaaa_aaaa, 1'b0);
    plan_item(MODE_PUSH,   32'h5555_5555, 1'b0);

    // fill A to the top, push past full, then reverse and transfer a full stack
    plan_item(MODE_CLEAR, 0, 1'b1);
    for (int i = 0; i < STACK_DEPTH; i++) plan_item(MODE_PUSH, pick_key(), 1'b0);
    for (int i = 0; i < 3; i++) plan_item(MODE_PUSH, pick_key(), 1'b0);
    plan_item(MODE_REV, 0, 1'b0);
    plan_item(MODE_POP, 0, 1'b0);
    plan_item(MODE_POP, 0, 1'b0);
    plan_item(MODE_PUSH, pick_key(), 1'b0);
    plan_item(MODE_PUSH, pick_key(), 1'b0);
    plan_item(MODE_CMP, 0, 1'b0);
    plan_item(MODE_XFER, 0, 1'b0);
    plan_item(MODE_CMP, 0, 1'b0);

    // random segments with different operation mixes
    while (cmd_plan.size() < TOTAL_ITEMS) begin
      profile = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 80);
      for (int i = 0; i < seg_len && cmd_plan.size() < TOTAL_ITEMS; i++)
        plan_item(pick_op(profile), pick_key(), (i == 0) && ($urandom_range(0, 5) == 0));
    end
  endtask

  function automatic bit cmdi_fixed(int idx);
    if (idx >= cmd_plan.size()) return 1'b0;
    return cmd_plan[idx].has_fixed;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // scoreboard: predict on command accept, compare on result accept
  always @(posedge clk) begin
    stack_result_t exp_res;
    stack_result_t got_res;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        exp_res = predict_stack_op(cmd_ch.mode, cmd_ch.key_in);
        if (cmdi_fixed(cmds_taken)) exp_res = cmd_plan[cmds_taken].fixed_res;
        pending_results.push_back(exp_res);
        cmds_taken++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got_res.status   = res_ch.status;
        got_res.key      = res_ch.key_out;
        got_res.a_larger = res_ch.a_larger;
        got_res.count_a  = res_ch.count_a_out;
        got_res.count_b  = res_ch.count_b_out;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result item %0d: st=%0d key=%h al=%0d ca=%0d cb=%0d",
                     results_seen, got_res.status, got_res.key, got_res.a_larger,
                     got_res.count_a, got_res.count_b);
        end else begin
          exp_res = pending_results.pop_front();
          if (got_res !== exp_res) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"mismatch on item %0d: exp st=%0d key=%h al=%0d ca=%0d cb=%0d",
                        " got st=%0d key=%h al=%0d ca=%0d cb=%0d"},
                       results_seen, exp_res.status, exp_res.key, exp_res.a_larger,
                       exp_res.count_a, exp_res.count_b, got_res.status, got_res.key,
                       got_res.a_larger, got_res.count_a, got_res.count_b);
          end
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: stall patterns plus two long hold-offs
  initial begin
    int hold_left;
    int pat_left;
    int pattern;
    int tick;
    bit hold1_done;
    bit hold2_done;
    hold_left = 0;
    pat_left = 0;
    pattern = 0;
    tick = 0;
    hold1_done = 1'b0;
    hold2_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!hold1_done && results_seen >= 120) begin
        hold1_done = 1'b1;
        hold_left = 700;
        res_ch.ready <= 1'b0;
      end else if (!hold2_done && results_seen >= 600) begin
        hold2_done = 1'b1;
        hold_left = 400;
        res_ch.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pattern = $urandom_range(0, 4);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pattern)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= $urandom_range(0, 1);
          2: res_ch.ready <= ($urandom_range(0, 4) != 0);
          3: res_ch.ready <= tick[1];
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // command side: bursts and gaps, drain pauses, then end of run
  initial begin
    int idx;
    int burst_left;
    int gap_left;
    idx = 0;
    burst_left = 0;
    gap_left = 0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= MODE_CLEAR;
    cmd_ch.key_in <= '0;
    build_plan();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (idx < cmd_plan.size()) begin
      @(posedge clk);
      if (cmd_ch.valid && cmd_ch.ready) idx++;
      if (cmd_ch.valid && !cmd_ch.ready) begin
        // hold the offered item until taken
      end else if (idx >= cmd_plan.size()) begin
        cmd_ch.valid <= 1'b0;
      end else if (cmd_plan[idx].drain && results_seen != idx) begin
        cmd_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        cmd_ch.valid <= 1'b0;
      end else begin
        if (burst_left == 0) burst_left = $urandom_range(1, 60);
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode <= cmd_plan[idx].op;
        cmd_ch.key_in <= cmd_plan[idx].key;
        cmd_plan[idx].drain = 1'b0;
        burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      end
    end
    while (results_seen != cmd_plan.size()) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
